// ===== rtl/csum_pkg.sv =====
// Shared types and constants of the closest subset sum unit.
// Holds the sequencer state type, table word helpers and fixed field widths.
// No dependencies.
package csum_pkg;

  localparam int unsigned WORD_BITS = 64;
  localparam int unsigned WORD_LSB  = 6;
  localparam int unsigned TGT_BITS  = 12;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_ROW0,
    ST_VAL_RD,
    ST_VAL_SET,
    ST_ROW,
    ST_SEARCH,
    ST_PICK,
    ST_BT_TEST,
    ST_BT_VAL,
    ST_BT_BIT,
    ST_FLUSH
  } csum_state_e;

  // Position of the lowest set bit of a table word.
  function automatic logic [WORD_LSB-1:0] low_one(word_t w);
    logic [WORD_LSB-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = WORD_LSB'(i);
    end
    return idx;
  endfunction

  // Position of the highest set bit of a table word.
  function automatic logic [WORD_LSB-1:0] high_one(word_t w);
    logic [WORD_LSB-1:0] idx;
    idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (w[i]) idx = WORD_LSB'(i);
    end
    return idx;
  endfunction

endpackage

// ===== rtl/csum_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered reads.
// No dependencies.
module csum_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ===== rtl/closest_subset_sum.sv =====
// Closest subset sum unit. Items are loaded one per cycle while the unit is not busy.
// Table build: each item after the first adds a row of W = ceil(span/64) words, span = pos-neg+1
// (capped at SUM_SPAN), set one 64-bit word of the reach table per cycle; then search, backtrack.
// All-negative or all-positive choice: decide, scan and a flush. One result/cycle max.
// Reset (async, active low) clears counts, sums, target and sequencer; memories hold junk.
// Depends on csum_pkg and csum_ram.
module closest_subset_sum #(
  parameter int unsigned MAX_ITEMS  = 16,
  parameter int unsigned VALUE_BITS = 8,
  parameter int unsigned SUM_SPAN   = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  input  logic signed [csum_pkg::TGT_BITS-1:0] target_i,
  input  logic                                last_i,
  output logic                                busy_o,
  output logic                                res_valid_o,
  output logic signed [VALUE_BITS-1:0]        element_o,
  output logic signed [csum_pkg::TGT_BITS-1:0] closest_sum_o,
  output logic                                empty_res_o,
  output logic                                last_res_o
);
  import csum_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned IDX_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned WORDS = (SUM_SPAN + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned WC_W  = $clog2(WORDS + 2);
  localparam int unsigned CW_A  = VALUE_BITS + CNT_W + 2;
  localparam int unsigned CW_B  = $clog2(SUM_SPAN + 1) + 2;
  localparam int unsigned CW_AB = (CW_A > CW_B) ? CW_A : CW_B;
  localparam int unsigned CW    = (CW_AB > TGT_BITS + 2) ? CW_AB : TGT_BITS + 2;
  localparam int unsigned AW    = IDX_W + WB;
  localparam int unsigned VS_DEPTH = 1 << IDX_W;
  localparam int unsigned TB_DEPTH = 1 << AW;

  typedef logic signed [CW-1:0] col_t;
  localparam col_t SPAN_C = col_t'(SUM_SPAN);

  // Sequencer and list state
  csum_state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, k_q, k_d;
  col_t neg_q, neg_d, pos_q, pos_d, tgt_q, tgt_d;
  logic mode_neg_q, mode_neg_d;
  // Table geometry of the current list
  col_t cols_q, cols_d, zero_q, zero_d, c0_q, c0_d, sum_q, sum_d;
  logic zok_q, zok_d;
  logic [WC_W-1:0] wlim_q, wlim_d, t_q, t_d, rw_q, rw_d;
  logic [WORD_LSB:0] tail_q, tail_d;
  logic [IDX_W-1:0] j_q, j_d;
  // Row build shift
  col_t q_q, q_d;
  logic [WORD_LSB-1:0] r_q, r_d;
  logic iss_q, iss_d, ret_q, ret_d, bval_q, bval_d, vs_ret_q, vs_ret_d;
  word_t prevb_q, prevb_d;
  // Search and backtrack
  logic up_fnd_q, up_fnd_d, dn_fnd_q, dn_fnd_d;
  col_t up_col_q, up_col_d, dn_col_q, dn_col_d, col_q, col_d, cx_q, cx_d;
  logic [VALUE_BITS-1:0] x_q, x_d;
  // Pending result and output register
  logic pend_vld_q, pend_vld_d;
  logic [VALUE_BITS-1:0] pend_q, pend_d;
  logic res_vld_q, res_vld_d, empty_q, empty_d, lastr_q, lastr_d;
  logic [VALUE_BITS-1:0] elem_q, elem_d;
  logic [TGT_BITS-1:0] csum_q, csum_d;

  // Memory ports
  logic vs_we;
  logic [IDX_W-1:0] vs_waddr, vs_raddr;
  logic [VALUE_BITS-1:0] vs_rdata_a, vs_rdata_b;
  logic tb_we;
  logic [AW-1:0] tb_waddr, tb_ra, tb_rb;
  word_t tb_wdata, tb_rdata_a, tb_rdata_b;

  logic acc;
  logic emit_en;
  logic [VALUE_BITS-1:0] emit_val;

  assign busy_o = (state_q != ST_IDLE) | res_vld_q;
  assign acc    = start_i & ~busy_o;

  assign res_valid_o   = res_vld_q;
  assign element_o     = elem_q;
  assign closest_sum_o = csum_q;
  assign empty_res_o   = empty_q;
  assign last_res_o    = lastr_q;

  // Loaded values; port B always reads the first item for row zero and the backtrack end.
  csum_ram #(.WIDTH(VALUE_BITS), .DEPTH(VS_DEPTH)) u_vstore (
    .clk_i    (clk_i),
    .we_i     (vs_we),
    .waddr_i  (vs_waddr),
    .wdata_i  (value_i),
    .raddr_a_i(vs_raddr),
    .rdata_a_o(vs_rdata_a),
    .raddr_b_i(IDX_W'(0)),
    .rdata_b_o(vs_rdata_b)
  );

  // Reach table: row j, word w at {j, w}. Port A reads the plain word, port B the
  // word that supplies the shifted copy.
  csum_ram #(.WIDTH(WORD_BITS), .DEPTH(TB_DEPTH)) u_reach (
    .clk_i    (clk_i),
    .we_i     (tb_we),
    .waddr_i  (tb_waddr),
    .wdata_i  (tb_wdata),
    .raddr_a_i(tb_ra),
    .rdata_a_o(tb_rdata_a),
    .raddr_b_i(tb_rb),
    .rdata_b_o(tb_rdata_b)
  );

  // Next state
  always_comb begin
    col_t xs, cx, du, dd;
    logic upok, dnok;
    state_d = state_q;
    xs   = col_t'($signed(vs_rdata_a));
    cx   = col_q - xs;
    du   = up_col_q - c0_q;
    dd   = c0_q - dn_col_q;
    upok = up_fnd_q && (du < cols_q);
    dnok = dn_fnd_q && (dd < cols_q);
    unique case (state_q)
      ST_IDLE:    if (acc && last_i) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (tgt_q <= neg_q || tgt_q >= pos_q) state_d = ST_SCAN;
        else                                  state_d = ST_ROW0;
      end
      ST_SCAN:    if (k_q == cnt_q && !vs_ret_q) state_d = ST_FLUSH;
      ST_ROW0: begin
        if (t_q == wlim_q - WC_W'(1)) begin
          state_d = (cnt_q == CNT_W'(1)) ? ST_SEARCH : ST_VAL_RD;
        end
      end
      ST_VAL_RD:  state_d = ST_VAL_SET;
      ST_VAL_SET: state_d = ST_ROW;
      ST_ROW: begin
        if (t_q > wlim_q && !iss_q) begin
          state_d = (CNT_W'(j_q) + CNT_W'(1) == cnt_q) ? ST_SEARCH : ST_VAL_RD;
        end
      end
      ST_SEARCH:  if (t_q == wlim_q && !iss_q) state_d = ST_PICK;
      ST_PICK:    state_d = (upok || dnok) ? ST_BT_TEST : ST_FLUSH;
      ST_BT_TEST: begin
        if (j_q == '0 || col_q == zero_q) state_d = ST_FLUSH;
        else                              state_d = ST_BT_VAL;
      end
      ST_BT_VAL: begin
        if (!cx[CW-1] && cx < cols_q) state_d = ST_BT_BIT;
        else                          state_d = ST_BT_TEST;
      end
      ST_BT_BIT:  state_d = ST_BT_TEST;
      ST_FLUSH:   state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    col_t vin, cf, cc, xs, cx, v0c, ww, bidx, wcol, cw, base, du, dd;
    logic upok, dnok;
    word_t wd, bm, upm, uw, dw, tailm;
    logic [2*WORD_BITS-1:0] pair;

    cnt_d = cnt_q;  k_d = k_q;  neg_d = neg_q;  pos_d = pos_q;  tgt_d = tgt_q;
    mode_neg_d = mode_neg_q;
    cols_d = cols_q;  zero_d = zero_q;  c0_d = c0_q;  sum_d = sum_q;  zok_d = zok_q;
    wlim_d = wlim_q;  t_d = t_q;  rw_d = rw_q;  tail_d = tail_q;  j_d = j_q;
    q_d = q_q;  r_d = r_q;  prevb_d = prevb_q;
    iss_d = 1'b0;  ret_d = 1'b0;  bval_d = bval_q;  vs_ret_d = 1'b0;
    up_fnd_d = up_fnd_q;  dn_fnd_d = dn_fnd_q;  up_col_d = up_col_q;  dn_col_d = dn_col_q;
    col_d = col_q;  cx_d = cx_q;  x_d = x_q;
    pend_vld_d = pend_vld_q;  pend_d = pend_q;
    res_vld_d = 1'b0;  elem_d = elem_q;  csum_d = csum_q;  empty_d = empty_q;
    lastr_d = lastr_q;
    vs_we = 1'b0;  vs_waddr = cnt_q[IDX_W-1:0];  vs_raddr = j_q;
    tb_we = 1'b0;  tb_waddr = '0;  tb_wdata = '0;  tb_ra = '0;  tb_rb = '0;
    emit_en = 1'b0;  emit_val = vs_rdata_a;

    vin  = col_t'(value_i);
    cf   = pos_q - neg_q + col_t'(1);
    cc   = (cf > SPAN_C) ? SPAN_C : cf;
    xs   = col_t'($signed(vs_rdata_a));
    cx   = col_q - xs;
    v0c  = col_t'($signed(vs_rdata_b)) - neg_q;
    ww   = col_t'(t_q);
    bidx = col_t'(t_q) + q_q;
    wcol = col_t'(rw_q);
    cw   = c0_q >>> WORD_LSB;
    base = wcol <<< WORD_LSB;
    du   = up_col_q - c0_q;
    dd   = c0_q - dn_col_q;
    upok = up_fnd_q && (du < cols_q);
    dnok = dn_fnd_q && (dd < cols_q);
    bm   = bval_q ? tb_rdata_b : '0;
    pair = {bm, prevb_q};
    tailm = (tail_q == (WORD_LSB + 1)'(WORD_BITS)) ? '1 : ((word_t'(1) << tail_q) - word_t'(1));
    if (wcol > cw)       upm = '1;
    else if (wcol == cw) upm = ~((word_t'(1) << c0_q[WORD_LSB-1:0]) - word_t'(1));
    else                 upm = '0;
    uw = tb_rdata_a & upm;
    dw = tb_rdata_a & ~upm;
    wd = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          // Drop items past capacity; a last mark still closes the list.
          if (cnt_q < CNT_W'(MAX_ITEMS)) begin
            vs_we = 1'b1;
            cnt_d = cnt_q + CNT_W'(1);
            if (vin < 0) neg_d = neg_q + vin;
            else         pos_d = pos_q + vin;
          end
          if (last_i) tgt_d = col_t'(target_i);
        end
      end
      ST_DECIDE: begin
        cols_d   = cc;
        wlim_d   = WC_W'((cc + col_t'(WORD_BITS - 1)) >>> WORD_LSB);
        tail_d   = (cc[WORD_LSB-1:0] == '0) ? (WORD_LSB + 1)'(WORD_BITS)
                                           : {1'b0, cc[WORD_LSB-1:0]};
        zero_d   = -neg_q;
        zok_d    = (-neg_q) < cc;
        c0_d     = tgt_q - neg_q;
        t_d      = '0;
        k_d      = '0;
        up_fnd_d = 1'b0;
        dn_fnd_d = 1'b0;
        if (tgt_q <= neg_q) begin
          mode_neg_d = 1'b1;
          sum_d      = neg_q;
        end else begin
          mode_neg_d = 1'b0;
          sum_d      = pos_q;
        end
      end
      ST_SCAN: begin
        if (k_q < cnt_q) begin
          vs_raddr = k_q[IDX_W-1:0];
          k_d      = k_q + CNT_W'(1);
          vs_ret_d = 1'b1;
        end
        if (vs_ret_q && ((mode_neg_q && xs < 0) || (!mode_neg_q && xs > 0))) begin
          emit_en  = 1'b1;
          emit_val = vs_rdata_a;
        end
      end
      ST_ROW0: begin
        if (!v0c[CW-1] && v0c < cols_q && (v0c >>> WORD_LSB) == ww)
          wd[v0c[WORD_LSB-1:0]] = 1'b1;
        if (zok_q && (zero_q >>> WORD_LSB) == ww) wd[zero_q[WORD_LSB-1:0]] = 1'b1;
        tb_we    = 1'b1;
        tb_waddr = {IDX_W'(0), t_q[WB-1:0]};
        tb_wdata = wd;
        t_d      = t_q + WC_W'(1);
        if (t_q == wlim_q - WC_W'(1)) begin
          t_d = '0;
          j_d = IDX_W'(1);
        end
      end
      ST_VAL_RD: vs_raddr = j_q;
      ST_VAL_SET: begin
        q_d = (-xs) >>> WORD_LSB;
        r_d = WORD_LSB'(-xs);
        t_d = '0;
      end
      ST_ROW: begin
        // Issue plain word t-1 and shift-source word t+q of the previous row.
        if (t_q <= wlim_q) begin
          iss_d  = 1'b1;
          ret_d  = (t_q != '0);
          rw_d   = t_q - WC_W'(1);
          bval_d = !bidx[CW-1] && (bidx < col_t'(wlim_q));
          tb_ra  = {IDX_W'(j_q - IDX_W'(1)), WB'(t_q - WC_W'(1))};
          tb_rb  = {IDX_W'(j_q - IDX_W'(1)), bidx[WB-1:0]};
          t_d    = t_q + WC_W'(1);
        end
        if (iss_q) prevb_d = bm;
        if (ret_q) begin
          wd = tb_rdata_a | word_t'(pair >> r_q);
          if (zok_q && (zero_q >>> WORD_LSB) == wcol) wd[zero_q[WORD_LSB-1:0]] = 1'b1;
          if (rw_q == wlim_q - WC_W'(1)) wd = wd & tailm;
          tb_we    = 1'b1;
          tb_waddr = {j_q, rw_q[WB-1:0]};
          tb_wdata = wd;
        end
        if (t_q > wlim_q && !iss_q) begin
          t_d = '0;
          if (CNT_W'(j_q) + CNT_W'(1) != cnt_q) j_d = j_q + IDX_W'(1);
        end
      end
      ST_SEARCH: begin
        if (t_q < wlim_q) begin
          iss_d = 1'b1;
          rw_d  = t_q;
          tb_ra = {IDX_W'(cnt_q - CNT_W'(1)), t_q[WB-1:0]};
          t_d   = t_q + WC_W'(1);
        end
        if (iss_q) begin
          // Keep the first set bit at or above the target column, the last below it.
          if (!up_fnd_q && (|uw)) begin
            up_fnd_d = 1'b1;
            up_col_d = base + col_t'(low_one(uw));
          end
          if (|dw) begin
            dn_fnd_d = 1'b1;
            dn_col_d = base + col_t'(high_one(dw));
          end
        end
      end
      ST_PICK: begin
        // Ties go to the higher sum.
        if (upok && (!dnok || du <= dd)) col_d = up_col_q;
        else                             col_d = dn_col_q;
        sum_d = col_d + neg_q;
        j_d   = IDX_W'(cnt_q - CNT_W'(1));
      end
      ST_BT_TEST: begin
        if (j_q == '0) begin
          if (col_q != zero_q) begin
            emit_en  = 1'b1;
            emit_val = vs_rdata_b;
          end
        end else if (col_q != zero_q) begin
          vs_raddr = j_q;
        end
      end
      ST_BT_VAL: begin
        x_d   = vs_rdata_a;
        cx_d  = cx;
        tb_ra = {IDX_W'(j_q - IDX_W'(1)), cx[WB+WORD_LSB-1:WORD_LSB]};
        if (!(!cx[CW-1] && cx < cols_q)) j_d = j_q - IDX_W'(1);
      end
      ST_BT_BIT: begin
        if (tb_rdata_a[cx_q[WORD_LSB-1:0]]) begin
          emit_en  = 1'b1;
          emit_val = x_q;
          col_d    = cx_q;
        end
        j_d = j_q - IDX_W'(1);
      end
      ST_FLUSH: begin
        // Release the held item as the final result, or report the empty subset.
        res_vld_d = 1'b1;
        lastr_d   = 1'b1;
        if (pend_vld_q) begin
          elem_d  = pend_q;
          csum_d  = sum_q[TGT_BITS-1:0];
          empty_d = 1'b0;
        end else begin
          elem_d  = '0;
          csum_d  = '0;
          empty_d = 1'b1;
        end
        pend_vld_d = 1'b0;
        cnt_d      = '0;
        neg_d      = '0;
        pos_d      = '0;
      end
      default: ;
    endcase

    // Hold each chosen value one step so the final one can carry the last mark.
    if (emit_en) begin
      if (pend_vld_q) begin
        res_vld_d = 1'b1;
        elem_d    = pend_q;
        csum_d    = sum_q[TGT_BITS-1:0];
        empty_d   = 1'b0;
        lastr_d   = 1'b0;
      end
      pend_d     = emit_val;
      pend_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      neg_q      <= '0;
      pos_q      <= '0;
      tgt_q      <= '0;
      iss_q      <= 1'b0;
      ret_q      <= 1'b0;
      vs_ret_q   <= 1'b0;
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      neg_q      <= neg_d;
      pos_q      <= pos_d;
      tgt_q      <= tgt_d;
      iss_q      <= iss_d;
      ret_q      <= ret_d;
      vs_ret_q   <= vs_ret_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    mode_neg_q <= mode_neg_d;
    cols_q     <= cols_d;
    zero_q     <= zero_d;
    zok_q      <= zok_d;
    c0_q       <= c0_d;
    sum_q      <= sum_d;
    wlim_q     <= wlim_d;
    t_q        <= t_d;
    rw_q       <= rw_d;
    tail_q     <= tail_d;
    j_q        <= j_d;
    q_q        <= q_d;
    r_q        <= r_d;
    bval_q     <= bval_d;
    prevb_q    <= prevb_d;
    up_fnd_q   <= up_fnd_d;
    dn_fnd_q   <= dn_fnd_d;
    up_col_q   <= up_col_d;
    dn_col_q   <= dn_col_d;
    col_q      <= col_d;
    cx_q       <= cx_d;
    x_q        <= x_d;
    pend_q     <= pend_d;
    elem_q     <= elem_d;
    csum_q     <= csum_d;
    empty_q    <= empty_d;
    lastr_q    <= lastr_d;
  end

endmodule

// ===== rtl/csum_chk.sv =====
// Port-level checks of the closest subset sum unit, bound to its top level.
// Depends on csum_pkg for field widths.
module csum_chk #(
  parameter int unsigned VALUE_BITS = 8
) (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                last_i,
  input logic                                busy_o,
  input logic                                res_valid_o,
  input logic [VALUE_BITS-1:0]               element_o,
  input logic [csum_pkg::TGT_BITS-1:0]       closest_sum_o,
  input logic                                empty_res_o,
  input logic                                last_res_o
);
  import csum_pkg::*;

  // A result only shows while the unit reports busy.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy_o) else $error("result outside busy window");

  // An accepted last item always starts the evaluation.
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_i) |=> busy_o) else $error("last item did not start work");

  // Nothing follows the final result of a list in the next cycle.
  a_final_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && last_res_o) |=> !res_valid_o) else $error("result after final one");

  // The empty subset is a single final result with zero payload.
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && empty_res_o) |-> (last_res_o && element_o == '0 && closest_sum_o == '0))
    else $error("malformed empty result");

endmodule

bind closest_subset_sum csum_chk #(.VALUE_BITS(VALUE_BITS)) u_csum_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .last_i       (last_i),
  .busy_o       (busy_o),
  .res_valid_o  (res_valid_o),
  .element_o    (element_o),
  .closest_sum_o(closest_sum_o),
  .empty_res_o  (empty_res_o),
  .last_res_o   (last_res_o)
);

// ===== tb/sv/csum_checker.sv =====
// Checker of the closest subset sum unit: watches the item and result ports,
// predicts the chosen subset of each list and compares every result field.
// Depends on nothing but the unit's port widths.
module csum_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic signed [7:0]  value_i,
  input  logic signed [11:0] target_i,
  input  logic               last_i,
  input  logic               res_valid_i,
  input  logic signed [7:0]  element_i,
  input  logic signed [11:0] closest_sum_i,
  input  logic               empty_res_i,
  input  logic               last_res_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int MaxItems = 16;
  localparam int SumSpan  = 4096;

  typedef struct packed {
    logic [7:0]  element;
    logic [11:0] closest_sum;
    logic        empty_res;
    logic        last_res;
  } subset_res_t;

  subset_res_t subset_q[$];

  int           held_vals [MaxItems];
  bit [SumSpan-1:0] reach_rows [MaxItems];
  int           held_count;
  int           neg_total;
  int           pos_total;

  function automatic bit reach(int r, int c);
    if (r < 0 || r >= MaxItems || c < 0 || c >= SumSpan) return 1'b0;
    return reach_rows[r][c];
  endfunction

  function automatic void mark(int r, int c);
    if (r < 0 || r >= MaxItems || c < 0 || c >= SumSpan) return;
    reach_rows[r][c] = 1'b1;
  endfunction

  // Store one item; on the last one, choose the subset and queue its results.
  function automatic void pick_subset(int v, int tgt, bit is_last);
    int chosen[$];
    int total, n, lo, cols, zero, best, col, i, j, x, up, dn;
    bit found, neg;
    subset_res_t r;
    total = 0;
    if (held_count < MaxItems) begin
      held_vals[held_count] = v;
      held_count++;
      if (v < 0) neg_total += v;
      else pos_total += v;
    end
    if (!is_last) return;
    n = held_count;
    if (tgt <= neg_total || tgt >= pos_total) begin
      neg = (tgt <= neg_total);
      for (i = 0; i < n; i++) begin
        x = held_vals[i];
        if ((neg && x < 0) || (!neg && x > 0)) begin
          chosen.push_back(x);
          total += x;
        end
      end
    end else begin
      lo = neg_total;
      cols = pos_total - neg_total + 1;
      zero = -lo;
      best = 0;
      found = 1'b0;
      if (cols > SumSpan) cols = SumSpan;
      for (j = 0; j < n; j++) reach_rows[j] = '0;
      mark(0, held_vals[0] - lo);
      mark(0, zero);
      for (j = 1; j < n; j++) begin
        x = held_vals[j];
        for (i = 0; i < cols; i++) begin
          if (reach(j - 1, i) || i == zero ||
              (i - x >= 0 && i - x < cols && reach(j - 1, i - x)))
            mark(j, i);
        end
      end
      for (i = 0; i < cols && !found; i++) begin
        up = tgt + i - lo;
        dn = tgt - i - lo;
        if (up >= 0 && up < cols && reach(n - 1, up)) begin
          best = tgt + i;
          found = 1'b1;
        end else if (dn >= 0 && dn < cols && reach(n - 1, dn)) begin
          best = tgt - i;
          found = 1'b1;
        end
      end
      if (found) begin
        col = best - lo;
        j = n - 1;
        while (j > 0) begin
          x = held_vals[j];
          if (col + lo == 0) break;
          if (col - x >= 0 && col - x < cols && reach(j - 1, col - x)) begin
            chosen.push_back(x);
            col -= x;
          end
          j--;
        end
        if (j == 0 && col + lo != 0) chosen.push_back(held_vals[0]);
        total = best;
      end
    end
    held_count = 0;
    neg_total = 0;
    pos_total = 0;
    if (chosen.size() == 0) begin
      r = '{element: '0, closest_sum: '0, empty_res: 1'b1, last_res: 1'b1};
      subset_q.push_back(r);
      return;
    end
    foreach (chosen[k]) begin
      r.element     = chosen[k][7:0];
      r.closest_sum = total[11:0];
      r.empty_res   = 1'b0;
      r.last_res    = (k == chosen.size() - 1);
      subset_q.push_back(r);
    end
  endfunction

  initial begin
    fail_count_o = 0;
    held_count = 0;
    neg_total = 0;
    pos_total = 0;
  end

  assign pending_o = subset_q.size();

  always @(posedge clk_i) begin
    subset_res_t want;
    if (rst_ni) begin
      if (res_valid_i) begin
        if (subset_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got element %0d sum %0d",
                   $time, element_i, closest_sum_i);
          fail_count_o++;
        end else begin
          want = subset_q.pop_front();
          if ({element_i, closest_sum_i, empty_res_i, last_res_i} !== want) begin
            $display("%0t: mismatch, expected elem %0d sum %0d empty %0b last %0b,",
                     $time, $signed(want.element), $signed(want.closest_sum),
                     want.empty_res, want.last_res);
            $display("%0t:   got elem %0d sum %0d empty %0b last %0b", $time,
                     element_i, closest_sum_i, empty_res_i, last_res_i);
            fail_count_o++;
          end
        end
      end
      // Predict after the compare so an item never satisfies its own edge.
      if (start_i && !busy_i) pick_subset(value_i, target_i, last_i);
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the closest subset sum testbench: clock, reset, list stimulus and verdict.
// Depends on closest_subset_sum (with csum_pkg) and csum_checker.
module testbench;

  localparam int IdleLimit = 40000;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic signed [7:0]  value_i;
  logic signed [11:0] target_i;
  logic               last_i;
  logic               busy_o;
  logic               res_valid_o;
  logic signed [7:0]  element_o;
  logic signed [11:0] closest_sum_o;
  logic               empty_res_o;
  logic               last_res_o;
  int                 fail_count;
  int                 pending;
  int                 burst_left;
  int                 quiet_cycles;
  bit                 u_checker_seen_accept;

  closest_subset_sum dut (
    .clk_i, .rst_ni, .start_i, .value_i, .target_i, .last_i, .busy_o,
    .res_valid_o, .element_o, .closest_sum_o, .empty_res_o, .last_res_o
  );

  csum_checker u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .value_i, .target_i, .last_i,
    .res_valid_i(res_valid_o), .element_i(element_o), .closest_sum_i(closest_sum_o),
    .empty_res_i(empty_res_o), .last_res_i(last_res_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog: end the run when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || res_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Record whether the rising edge accepted the offered item.
  always @(posedge clk_i) u_checker_seen_accept = start_i && !busy_o;

  // Offer one item at the falling edge and hold it until accepted. Gaps
  // between bursts drop start for a random number of cycles.
  task automatic send_item(int v, int tgt, bit is_last);
    bit taken;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        start_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    start_i  <= 1'b1;
    value_i  <= v[7:0];
    target_i <= tgt[11:0];
    last_i   <= is_last;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      // busy was settled across the rising edge just passed
      taken = u_checker_seen_accept;
    end
  endtask

  // Send a whole list; the target rides on its last item only.
  task automatic send_list(int vals[$], int tgt);
    foreach (vals[k])
      send_item(vals[k], (k == vals.size() - 1) ? tgt : int'($urandom_range(0, 4095)),
                k == vals.size() - 1);
  endtask

  // Random list of values within +-mag with a target mostly between the two sums.
  task automatic random_list(int len, int mag, bit full_target);
    int vals[$];
    int v, neg, pos, tgt;
    neg = 0;
    pos = 0;
    for (int k = 0; k < len; k++) begin
      v = int'($urandom_range(0, 2 * mag)) - mag;
      vals.push_back(v);
      if (k < 16) begin
        if (v < 0) neg += v;
        else pos += v;
      end
    end
    if (full_target) tgt = int'($urandom_range(0, 4095)) - 2048;
    else tgt = int'($urandom_range(0, pos - neg + 2)) + neg - 1;
    send_list(vals, tgt);
  endtask

  initial begin
    int items;
    start_i  = 1'b0;
    value_i  = '0;
    target_i = '0;
    last_i   = 1'b0;
    burst_left = 0;
    quiet_cycles = 0;
    u_checker_seen_accept = 1'b0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed lists: field extremes, both whole-sign choices, empty subset,
    // zero values, ties, and a list longer than the store.
    send_list('{-128}, -2048);
    send_list('{127}, 2047);
    send_list('{0}, 0);
    send_list('{-5, 7}, -5);
    send_list('{-5, 7}, 7);
    send_list('{-5, 7, 0}, 1);
    send_list('{3, -3, 0}, 0);
    send_list('{4, -4}, 2);
    send_list('{2, 6}, 4);
    send_list('{-128, 127, 1}, -1);
    send_list('{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, -50, 60}, 9);

    // Random lists: mostly short with small values so the table stays narrow,
    // a few full-size ones, and some targets across the whole field.
    items = 0;
    while (items < 122) begin
      int len, mag;
      case ($urandom_range(0, 9))
        0:       begin len = $urandom_range(14, 18); mag = 128; end
        1, 2:    begin len = $urandom_range(1, 8);   mag = 128; end
        default: begin len = $urandom_range(1, 6);   mag = 12;  end
      endcase
      if (mag == 128) mag = 127;
      random_list(len, mag, $urandom_range(0, 4) == 0);
      items += len;
    end

    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
